>>> rtl/hptc_pkg.sv
// Package with shared types and codes of the hit pattern track classifier.
package hptc_pkg;

    localparam int PATTERN_W = 9;
    localparam int MODE_W    = 3;
    localparam int CLASS_W   = 3;

    // Table selector codes.
    localparam logic [MODE_W-1:0] MODE_VERTICAL   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HORIZONTAL = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INNER_OUTER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ZONES6     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ZONES8     = 3'd4;

    // Track class codes for the vertical and horizontal tables.
    localparam logic [CLASS_W-1:0] CLASS_NONE  = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_OUTER = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_INNER = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_FULL  = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_RIGHT = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_LEFT  = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_WIDE  = 3'd3;

    // Inner/outer exception patterns on the low eight bits.
    localparam logic [7:0] IO_EXCEPT_A = 8'h81;
    localparam logic [7:0] IO_EXCEPT_B = 8'h42;

    // Features extracted from one hit pattern in the first stage.
    typedef struct packed {
        logic [2:0] cnt_outer;    // set bits among 4..8
        logic [2:0] cnt_inner;    // set bits among 0..5
        logic [3:0] cnt_full;     // set bits among 0..8
        logic [3:0] cnt_low8;     // set bits among 0..7
        logic       left_end;
        logic       right_end;
        logic       top_clear;
        logic       bottom_clear;
        logic       io_except;
        logic       io_inner;
        logic       io_outer;
        logic [2:0] zones6;
        logic [2:0] zones8;
    } feat_t;

    // Class candidates for every table, computed in the second stage.
    typedef struct packed {
        logic [CLASS_W-1:0] vertical;
        logic [CLASS_W-1:0] horizontal;
        logic [CLASS_W-1:0] inner_outer;
        logic [CLASS_W-1:0] zones6;
        logic [CLASS_W-1:0] zones8;
    } cand_t;

endpackage

>>> rtl/hit_pattern_track_classifier.sv
// Top level of the hit pattern track classifier: three-stage pipeline and mode register.
//
//  channel   | signals                              | carries
//  ----------+--------------------------------------+--------------------------------
//  s_axis    | s_tvalid, s_tready, s_tdata[15:0]    | hit_pattern in bits 8:0
//  m_axis    | m_tvalid, m_tready, m_tdata[7:0]     | class_code in bits 2:0
//  config    | table_mode_we, table_mode_wdata[2:0] | table_mode, reset value 0
//
// One item may enter every cycle unless a stalled output has filled the pipeline.
// Stage 1 extracts counts, run flags, inner/outer flags and zone ORs, stage 2 forms the
// class of every table, stage 3 selects by table_mode into the output register.
// A stage takes a new item when it is empty or its item moves on, so a
// stalled output only blocks once the whole pipeline is full.
// Reset clears all valid bits and sets table_mode to vertical.
module hit_pattern_track_classifier
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [15:0] s_tdata,          // [8:0] hit_pattern
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,           // [2:0] class_code
    input  logic       table_mode_we,
    input  logic [2:0] table_mode_wdata
);

    logic [hptc_pkg::MODE_W-1:0]  table_mode_reg;
    logic                         v1_reg;
    logic                         v2_reg;
    logic                         vo_reg;
    hptc_pkg::feat_t              feat_reg;
    hptc_pkg::feat_t              feat_next;
    hptc_pkg::cand_t              cand_reg;
    hptc_pkg::cand_t              cand_next;
    logic [hptc_pkg::CLASS_W-1:0] class_reg;
    logic [hptc_pkg::CLASS_W-1:0] class_next;
    logic                         rdy_o;
    logic                         rdy2;
    logic                         rdy1;

    assign rdy_o    = !vo_reg || m_tready;
    assign rdy2     = !v2_reg || rdy_o;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    hptc_features u_features
    (
        .pattern (s_tdata[hptc_pkg::PATTERN_W-1:0]),
        .feat    (feat_next)
    );

    // Stage 2: turn the features into the class code of every table.
    always_comb
    begin
        if (feat_reg.cnt_full >= 4'd6)
        begin
            cand_next.vertical = hptc_pkg::CLASS_FULL;
        end
        else if (feat_reg.cnt_inner >= 3'd3)
        begin
            cand_next.vertical = hptc_pkg::CLASS_INNER;
        end
        else if (feat_reg.cnt_outer >= 3'd3)
        begin
            cand_next.vertical = hptc_pkg::CLASS_OUTER;
        end
        else
        begin
            cand_next.vertical = hptc_pkg::CLASS_NONE;
        end

        // A wide track with few hits leans away from the end whose edge bits are clear.
        if (feat_reg.cnt_low8 >= 4'd6)
        begin
            cand_next.horizontal = hptc_pkg::CLASS_WIDE;
        end
        else if (feat_reg.left_end && feat_reg.right_end)
        begin
            if (feat_reg.top_clear)
            begin
                cand_next.horizontal = hptc_pkg::CLASS_LEFT;
            end
            else if (feat_reg.bottom_clear)
            begin
                cand_next.horizontal = hptc_pkg::CLASS_RIGHT;
            end
            else
            begin
                cand_next.horizontal = hptc_pkg::CLASS_WIDE;
            end
        end
        else if (feat_reg.left_end)
        begin
            cand_next.horizontal = hptc_pkg::CLASS_LEFT;
        end
        else if (feat_reg.right_end)
        begin
            cand_next.horizontal = hptc_pkg::CLASS_RIGHT;
        end
        else
        begin
            cand_next.horizontal = hptc_pkg::CLASS_NONE;
        end

        if (feat_reg.io_except)
        begin
            cand_next.inner_outer = 3'b001;
        end
        else
        begin
            cand_next.inner_outer = {1'b0, feat_reg.io_outer, feat_reg.io_inner};
        end

        cand_next.zones6 = feat_reg.zones6;
        cand_next.zones8 = feat_reg.zones8;
    end

    // Stage 3: pick the table that the mode register selects.
    always_comb
    begin
        case (table_mode_reg)
            hptc_pkg::MODE_VERTICAL:    class_next = cand_reg.vertical;
            hptc_pkg::MODE_HORIZONTAL:  class_next = cand_reg.horizontal;
            hptc_pkg::MODE_INNER_OUTER: class_next = cand_reg.inner_outer;
            hptc_pkg::MODE_ZONES6:      class_next = cand_reg.zones6;
            hptc_pkg::MODE_ZONES8:      class_next = cand_reg.zones8;
            default:                    class_next = hptc_pkg::CLASS_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_mode_reg <= hptc_pkg::MODE_VERTICAL;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            vo_reg         <= 1'b0;
        end
        else
        begin
            if (table_mode_we)
            begin
                table_mode_reg <= table_mode_wdata;
            end
            if (rdy1)
            begin
                v1_reg <= s_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy_o)
            begin
                vo_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_tvalid)
        begin
            feat_reg <= feat_next;
        end
        if (rdy2 && v1_reg)
        begin
            cand_reg <= cand_next;
        end
        if (rdy_o && v2_reg)
        begin
            class_reg <= class_next;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {5'b0, class_reg};

`ifndef SYNTHESIS
    property p_accept_fills_stage1;
        @(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v1_reg;
    endproperty
    a_accept_fills_stage1: assert property (p_accept_fills_stage1)
        else $error("accepted item did not enter stage 1");

    property p_empty_output_ready;
        @(posedge clk) disable iff (!rst_n)
        !vo_reg |-> s_tready;
    endproperty
    a_empty_output_ready: assert property (p_empty_output_ready)
        else $error("input stalled while the output stage is empty");

    property p_undefined_mode_none;
        @(posedge clk) disable iff (!rst_n)
        rdy_o && v2_reg && table_mode_reg > hptc_pkg::MODE_ZONES8
        |=> m_tdata[2:0] == hptc_pkg::CLASS_NONE;
    endproperty
    a_undefined_mode_none: assert property (p_undefined_mode_none)
        else $error("undefined table mode gave a nonzero class");

    property p_io_bit2_clear;
        @(posedge clk) disable iff (!rst_n)
        rdy_o && v2_reg && table_mode_reg == hptc_pkg::MODE_INNER_OUTER
        |=> !m_tdata[2];
    endproperty
    a_io_bit2_clear: assert property (p_io_bit2_clear)
        else $error("inner/outer class has bit 2 set");
`endif

endmodule

>>> rtl/hptc_features.sv
// Features of a hit pattern: bit counts, end runs, inner/outer flags and zone ORs.
module hptc_features
(
    input  logic [hptc_pkg::PATTERN_W-1:0] pattern,
    output hptc_pkg::feat_t                feat
);

    logic [2:0] outer_n;
    logic [2:0] inner_n;
    logic [3:0] low8_n;
    logic       left_any;
    logic       right_any;

    always_comb
    begin
        outer_n = '0;
        inner_n = '0;
        low8_n  = '0;
        for (int i = 4; i <= 8; i++)
        begin
            outer_n = outer_n + 3'(pattern[i]);
        end
        for (int i = 0; i <= 5; i++)
        begin
            inner_n = inner_n + 3'(pattern[i]);
        end
        for (int i = 0; i <= 7; i++)
        begin
            low8_n = low8_n + 4'(pattern[i]);
        end
    end

    // Runs read upward from the bottom end and downward from the top end.
    always_comb
    begin
        left_any  = 1'b0;
        right_any = 1'b0;
        for (int k = 0; k <= 2; k++)
        begin
            if ((pattern[k] & pattern[k+1] & pattern[k+2]) ||
                (pattern[k] & pattern[k+1] & !pattern[k+2] & pattern[k+3]) ||
                (pattern[k] & !pattern[k+1] & pattern[k+2] & pattern[k+3]))
            begin
                left_any = 1'b1;
            end
            if (pattern[7-k] & pattern[6-k] & pattern[5-k])
            begin
                right_any = 1'b1;
            end
        end
        for (int k = 0; k <= 1; k++)
        begin
            if ((pattern[7-k] & pattern[6-k] & !pattern[5-k] & pattern[4-k]) ||
                (pattern[7-k] & !pattern[6-k] & pattern[5-k] & pattern[4-k]))
            begin
                right_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        feat.cnt_outer    = outer_n;
        feat.cnt_inner    = inner_n;
        feat.cnt_low8     = low8_n;
        feat.cnt_full     = low8_n + 4'(pattern[8]);
        feat.left_end     = left_any;
        feat.right_end    = right_any;
        feat.top_clear    = !(pattern[7] | pattern[6]);
        feat.bottom_clear = !(pattern[1] | pattern[0]);
        feat.io_except    = (pattern[7:0] == hptc_pkg::IO_EXCEPT_A) ||
                            (pattern[7:0] == hptc_pkg::IO_EXCEPT_B);
        feat.io_inner     = pattern[0] | pattern[2] | pattern[4] | pattern[6];
        feat.io_outer     = pattern[1] | pattern[3] | pattern[5] | pattern[7];
        feat.zones6       = {pattern[5] | pattern[4], pattern[3] | pattern[2],
                             pattern[1] | pattern[0]};
        feat.zones8       = {pattern[7] | pattern[6], |pattern[5:2],
                             pattern[1] | pattern[0]};
    end

endmodule

>>> tb/hit_pattern_track_classifier_test.sv
// Self-checking testbench of the hit pattern track classifier: all tables, random stalls.
`timescale 1ns / 100ps

module hit_pattern_track_classifier_test;

    localparam int STALL_LIMIT = 1000;
    localparam int IDLE_PCT    = 9;
    localparam int DRAIN_WAIT  = 12;

    // Selector values that no table is assigned to; the block outputs none for them.
    localparam logic [hptc_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [hptc_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    // Bit flags of the inner/outer and zone tables.
    localparam logic [hptc_pkg::CLASS_W-1:0] FLAG_LOW = 3'b001;

    // Run shapes of the horizontal table, bit 0 of each constant is the first hit of the run.
    localparam logic [2:0] RUN_111  = 3'b111;
    localparam logic [3:0] RUN_1101 = 4'b1011;
    localparam logic [3:0] RUN_1011 = 4'b1101;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        table_mode_we = 1'b0;
    logic [2:0]  table_mode_wdata = '0;

    logic [hptc_pkg::PATTERN_W-1:0] pattern_q[$];
    logic [hptc_pkg::CLASS_W-1:0]   class_expect_q[$];
    logic [hptc_pkg::MODE_W-1:0]    mode_now = hptc_pkg::MODE_VERTICAL;
    logic                           idle_on = 1'b1;
    logic                           offer_busy;
    logic [hptc_pkg::CLASS_W-1:0]   class_want;
    int                             err_cnt = 0;
    int                             stall_cycles = 0;

    hit_pattern_track_classifier u_top
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .table_mode_we    (table_mode_we),
        .table_mode_wdata (table_mode_wdata)
    );

    always #1 clk = ~clk;

    function automatic logic [hptc_pkg::CLASS_W-1:0] track_class(
        input logic [hptc_pkg::PATTERN_W-1:0] hits,
        input logic [hptc_pkg::MODE_W-1:0]    mode);
        logic [7:0] low;
        logic [7:0] flip;
        logic       left_end;
        logic       right_end;
        int         k;
        low = hits[7:0];
        for (k = 0; k < 8; k++)
        begin
            flip[k] = low[7 - k];
        end
        case (mode)
            hptc_pkg::MODE_VERTICAL:
            begin
                if ($countones(hits) >= 6)
                    return hptc_pkg::CLASS_FULL;
                if ($countones(hits[5:0]) >= 3)
                    return hptc_pkg::CLASS_INNER;
                if ($countones(hits[8:4]) >= 3)
                    return hptc_pkg::CLASS_OUTER;
                return hptc_pkg::CLASS_NONE;
            end
            hptc_pkg::MODE_HORIZONTAL:
            begin
                left_end  = 1'b0;
                right_end = 1'b0;
                // Runs at the left end read upward from bit 0, at the right end downward
                // from bit 7; the gapped runs at the right end may start one place less deep.
                for (k = 0; k <= 2; k++)
                begin
                    if (low[k +: 3] == RUN_111 || low[k +: 4] == RUN_1101
                        || low[k +: 4] == RUN_1011)
                        left_end = 1'b1;
                    if (flip[k +: 3] == RUN_111)
                        right_end = 1'b1;
                    if (k <= 1 && (flip[k +: 4] == RUN_1101 || flip[k +: 4] == RUN_1011))
                        right_end = 1'b1;
                end
                if ($countones(low) >= 6)
                    return hptc_pkg::CLASS_WIDE;
                if (left_end && right_end)
                begin
                    if (low[7:6] == 2'b00)
                        return hptc_pkg::CLASS_LEFT;
                    if (low[1:0] == 2'b00)
                        return hptc_pkg::CLASS_RIGHT;
                    return hptc_pkg::CLASS_WIDE;
                end
                if (left_end)
                    return hptc_pkg::CLASS_LEFT;
                if (right_end)
                    return hptc_pkg::CLASS_RIGHT;
                return hptc_pkg::CLASS_NONE;
            end
            hptc_pkg::MODE_INNER_OUTER:
            begin
                if (low == hptc_pkg::IO_EXCEPT_A || low == hptc_pkg::IO_EXCEPT_B)
                    return FLAG_LOW;
                return {1'b0, |(low & 8'hAA), |(low & 8'h55)};
            end
            hptc_pkg::MODE_ZONES6:
                return {|hits[5:4], |hits[3:2], |hits[1:0]};
            hptc_pkg::MODE_ZONES8:
                return {|hits[7:6], |hits[5:2], |hits[1:0]};
            default:
                return hptc_pkg::CLASS_NONE;
        endcase
    endfunction

    // Driver: offers the pending hit patterns and predicts the class of each accepted item.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            offer_busy = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                class_expect_q.push_back(track_class(s_tdata[hptc_pkg::PATTERN_W-1:0],
                                                     mode_now));
                void'(pattern_q.pop_front());
                offer_busy = 1'b0;
            end
            if (!offer_busy)
            begin
                if (pattern_q.size() > 0 && !(idle_on && $urandom_range(99) < IDLE_PCT))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(16 - hptc_pkg::PATTERN_W){1'b0}}, pattern_q[0]};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares every result with the oldest predicted class.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (class_expect_q.size() == 0)
                begin
                    $error("class_code: no result expected, actual %0d",
                           m_tdata[hptc_pkg::CLASS_W-1:0]);
                    err_cnt++;
                end
                else
                begin
                    class_want = class_expect_q.pop_front();
                    if (m_tdata[hptc_pkg::CLASS_W-1:0] !== class_want)
                    begin
                        $error("class_code: expected %0d, actual %0d", class_want,
                               m_tdata[hptc_pkg::CLASS_W-1:0]);
                        err_cnt++;
                    end
                end
            end
            m_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Waits until the sender has nothing left and every predicted class has come back.
    task automatic drain();
        while (pattern_q.size() > 0 || class_expect_q.size() > 0 || s_tvalid)
            @(negedge clk);
    endtask

    task automatic set_mode(input logic [hptc_pkg::MODE_W-1:0] mode);
        @(posedge clk);
        table_mode_we    <= 1'b1;
        table_mode_wdata <= mode;
        @(posedge clk);
        table_mode_we <= 1'b0;
        mode_now = mode;
        @(negedge clk);
    endtask

    initial
    begin
        logic [hptc_pkg::PATTERN_W-1:0] hits;
        logic [hptc_pkg::MODE_W-1:0]    mode;
        int                             ph;
        int                             n;
        int                             count;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: the reset table, every table with its corner patterns, two unused selectors.
        pattern_q = '{9'h000, 9'h1FF, 9'h007, 9'h070, 9'h03F};
        drain();
        set_mode(hptc_pkg::MODE_HORIZONTAL);
        pattern_q = '{9'h007, 9'h0E0, 9'h0D0, 9'h03C, 9'h07C, 9'h0CB, 9'h1FF};
        drain();
        set_mode(hptc_pkg::MODE_INNER_OUTER);
        pattern_q = '{9'h081, 9'h042, 9'h155, 9'h0AA, 9'h181};
        drain();
        set_mode(hptc_pkg::MODE_ZONES6);
        pattern_q = '{9'h030, 9'h00C, 9'h003, 9'h1C0};
        drain();
        set_mode(hptc_pkg::MODE_ZONES8);
        pattern_q = '{9'h0C0, 9'h03C, 9'h100};
        drain();
        set_mode(MODE_UNUSED_HI);
        pattern_q = '{9'h1FF};
        drain();
        set_mode(MODE_UNUSED_LO);
        pattern_q = '{9'h155};
        drain();

        // Random: every table in turn, then selectors drawn at random. One phase runs
        // without any idling on either side.
        for (ph = 0; ph < 10; ph++)
        begin
            mode    = (ph < 5) ? ph[hptc_pkg::MODE_W-1:0]
                               : hptc_pkg::MODE_W'($urandom_range(7));
            count   = (ph < 5) ? 60 : 25;
            idle_on = (ph != 2);
            set_mode(mode);
            for (n = 0; n < count; n++)
            begin
                case ($urandom_range(3))
                    0: hits = hptc_pkg::PATTERN_W'($urandom);
                    // A short run somewhere plus a stray hit or two.
                    1: hits = hptc_pkg::PATTERN_W'((($urandom_range(1) ? 4'hF : 4'h7)
                                                    << $urandom_range(5))
                                                   | ($urandom & $urandom & $urandom));
                    2: hits = hptc_pkg::PATTERN_W'($urandom & $urandom);
                    default: hits = hptc_pkg::PATTERN_W'($urandom | $urandom);
                endcase
                pattern_q.push_back(hits);
            end
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (class_expect_q.size() != 0)
        begin
            $error("class_code: %0d expected results never arrived", class_expect_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
